/* src/olie_pkg.sv */
`timescale 1ns / 1ps

package olie_pkg;

    // Action codes carried in the input tuser field.
    localparam logic [2:0] ACT_INSERT   = 3'd0;
    localparam logic [2:0] ACT_REMOVE   = 3'd1;
    localparam logic [2:0] ACT_GET      = 3'd2;
    localparam logic [2:0] ACT_INDEX_OF = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    // Status codes carried in the output tuser field.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } olie_state_t;

    // Per-cycle command broadcast to every cell of the list.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic find_pos;
        logic find_value;
    } olie_ctrl_t;

    // Flags of the search probe that walks the cell chain.
    typedef struct packed {
        logic valid;
        logic found;
    } olie_probe_t;

endpackage

/* src/olie_cell.sv */
`timescale 1ns / 1ps

module olie_cell #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(DEPTH)-1:0]     cell_index,
    input  olie_pkg::olie_ctrl_t         ctrl,
    input  logic [$clog2(DEPTH)-1:0]     pos,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [VALUE_WIDTH-1:0]       value,
    input  logic [VALUE_WIDTH-1:0]       prev_value,
    input  logic [VALUE_WIDTH-1:0]       next_value,
    output logic [VALUE_WIDTH-1:0]       entry,
    input  olie_pkg::olie_probe_t        probe_in,
    input  logic [VALUE_WIDTH-1:0]       probe_data_in,
    input  logic [$clog2(DEPTH)-1:0]     probe_index_in,
    output olie_pkg::olie_probe_t        probe_out,
    output logic [VALUE_WIDTH-1:0]       probe_data_out,
    output logic [$clog2(DEPTH)-1:0]     probe_index_out
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    olie_pkg::olie_probe_t  probe_reg;
    olie_pkg::olie_probe_t  probe_next;
    logic [VALUE_WIDTH-1:0] probe_data_reg;
    logic [VALUE_WIDTH-1:0] probe_data_next;
    logic [IDX_W-1:0]       probe_index_reg;
    logic [IDX_W-1:0]       probe_index_next;
    logic                   occupied;
    logic                   hit;
    logic                   take;

    assign occupied = CNT_W'(cell_index) < count;
    assign hit = occupied && ((ctrl.find_pos && (cell_index == pos)) ||
                              (ctrl.find_value && (entry_reg == value)));
    // Only the first matching cell along the chain claims the probe.
    assign take = probe_in.valid && !probe_in.found && hit;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift_up)
        begin
            if (cell_index == pos)
            begin
                entry_next = value;
            end
            else if (cell_index > pos)
            begin
                entry_next = prev_value;
            end
        end
        else if (ctrl.shift_down)
        begin
            if (cell_index >= pos)
            begin
                entry_next = next_value;
            end
        end

        probe_next.valid = probe_in.valid;
        probe_next.found = probe_in.found || take;
        probe_data_next  = take ? entry_reg : probe_data_in;
        probe_index_next = take ? cell_index : probe_index_in;
    end

    always_ff @(posedge clk)
    begin
        entry_reg       <= entry_next;
        probe_data_reg  <= probe_data_next;
        probe_index_reg <= probe_index_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    assign entry           = entry_reg;
    assign probe_out       = probe_reg;
    assign probe_data_out  = probe_data_reg;
    assign probe_index_out = probe_index_reg;

endmodule

/* src/ordered_list_insert_remove_engine_core.sv */
`timescale 1ns / 1ps
// Insert, clear and unused codes register their result on the edge after acceptance;
// these actions can be accepted every cycle while the output side keeps up.
// Remove, get and index-of send a probe down the chain of DEPTH cells, one cell per cycle;
// the result is captured when the probe leaves the last cell (S_SCAN) and is registered in
// S_RESP once the output side is free. No new action is accepted until the return to S_IDLE.
// Reset (rst_n low, asynchronous) empties the list; stored values are not cleared.
module ordered_list_insert_remove_engine_core #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] position, [38:7] item_value, [39] zero
    input  logic [39:0] s_axis_tdata,
    // [2:0] action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_value, [37:32] found_index, [44:38] entry_count, [47:45] zero
    output logic [47:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = CNT_W + 7;

    olie_pkg::olie_state_t  state_reg;
    olie_pkg::olie_state_t  state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [2:0]             act_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic                   pos_ok_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   launch_reg;
    logic                   launch_next;
    logic                   res_found_reg;
    logic [VALUE_WIDTH-1:0] res_data_reg;
    logic [IDX_W-1:0]       res_index_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             out_status_reg;
    logic [47:0]            out_data_reg;

    logic [2:0]             in_act;
    logic [6:0]             in_pos;
    logic [31:0]            in_val32;
    logic [VALUE_WIDTH+31:0] in_val_ext;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [IDX_W+6:0]       in_pos_ext;
    logic [IDX_W-1:0]       in_pos_idx;
    logic [CMP_W-1:0]       pos_cmp;
    logic [CMP_W-1:0]       cnt_cmp;
    logic                   pos_le;
    logic                   pos_lt;
    logic                   full;
    logic                   out_free;
    logic                   accept;
    logic                   capture_cmd;
    logic                   load_out;
    logic [1:0]             res_status;
    logic [VALUE_WIDTH-1:0] res_read;
    logic [IDX_W-1:0]       res_index;
    logic [VALUE_WIDTH+31:0] read_ext;
    logic [IDX_W+5:0]       index_ext;
    logic [CNT_W+6:0]       count_ext;

    olie_pkg::olie_ctrl_t   ctrl;
    logic [IDX_W-1:0]       cell_pos;
    logic [VALUE_WIDTH-1:0] cell_val;

    logic [VALUE_WIDTH-1:0] entry_w [DEPTH];
    olie_pkg::olie_probe_t  probe_w [DEPTH+1];
    logic [VALUE_WIDTH-1:0] probe_data_w [DEPTH+1];
    logic [IDX_W-1:0]       probe_index_w [DEPTH+1];

    assign in_act     = s_axis_tuser;
    assign in_pos     = s_axis_tdata[6:0];
    assign in_val32   = s_axis_tdata[38:7];
    assign in_val_ext = {{VALUE_WIDTH{1'b0}}, in_val32};
    assign in_val     = in_val_ext[VALUE_WIDTH-1:0];
    assign in_pos_ext = {{IDX_W{1'b0}}, in_pos};
    assign in_pos_idx = in_pos_ext[IDX_W-1:0];
    assign pos_cmp    = CMP_W'(in_pos);
    assign cnt_cmp    = CMP_W'(count_reg);
    assign pos_le     = pos_cmp <= cnt_cmp;
    assign pos_lt     = pos_cmp < cnt_cmp;
    assign full       = count_reg == CNT_W'(DEPTH);

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == olie_pkg::S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        launch_next = 1'b0;
        capture_cmd = 1'b0;
        load_out    = 1'b0;
        res_status  = olie_pkg::ST_OK;
        res_read    = '0;
        res_index   = '0;
        ctrl        = '0;
        cell_pos    = pos_reg;
        cell_val    = val_reg;

        unique case (state_reg)
            olie_pkg::S_IDLE:
            begin
                cell_pos = in_pos_idx;
                cell_val = in_val;
                if (accept)
                begin
                    unique case (in_act)
                        olie_pkg::ACT_INSERT:
                        begin
                            load_out = 1'b1;
                            if (!pos_le)
                            begin
                                res_status = olie_pkg::ST_MISS;
                            end
                            else if (full)
                            begin
                                res_status = olie_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.shift_up = 1'b1;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        olie_pkg::ACT_REMOVE, olie_pkg::ACT_GET, olie_pkg::ACT_INDEX_OF:
                        begin
                            capture_cmd = 1'b1;
                            launch_next = 1'b1;
                            state_next  = olie_pkg::S_SCAN;
                        end
                        olie_pkg::ACT_CLEAR:
                        begin
                            load_out   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load_out   = 1'b1;
                            res_status = olie_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            olie_pkg::S_SCAN:
            begin
                ctrl.find_pos   = pos_ok_reg && ((act_reg == olie_pkg::ACT_REMOVE) ||
                                                 (act_reg == olie_pkg::ACT_GET));
                ctrl.find_value = act_reg == olie_pkg::ACT_INDEX_OF;
                if (probe_w[DEPTH].valid)
                begin
                    state_next = olie_pkg::S_RESP;
                end
            end
            olie_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = olie_pkg::S_IDLE;
                    res_status = res_found_reg ? olie_pkg::ST_OK : olie_pkg::ST_MISS;
                    if (res_found_reg)
                    begin
                        if (act_reg == olie_pkg::ACT_INDEX_OF)
                        begin
                            res_index = res_index_reg;
                        end
                        else
                        begin
                            res_read = res_data_reg;
                        end
                        if (act_reg == olie_pkg::ACT_REMOVE)
                        begin
                            ctrl.shift_down = 1'b1;
                            count_next      = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = olie_pkg::S_IDLE;
            end
        endcase
    end

    assign read_ext  = {32'd0, res_read};
    assign index_ext = {6'd0, res_index};
    assign count_ext = {7'd0, count_next};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olie_pkg::S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture_cmd)
        begin
            act_reg    <= in_act;
            pos_reg    <= in_pos_idx;
            pos_ok_reg <= pos_lt;
            val_reg    <= in_val;
        end
        if ((state_reg == olie_pkg::S_SCAN) && probe_w[DEPTH].valid)
        begin
            res_found_reg <= probe_w[DEPTH].found;
            res_data_reg  <= probe_data_w[DEPTH];
            res_index_reg <= probe_index_w[DEPTH];
        end
        if (load_out)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= {3'd0, count_ext[6:0], index_ext[5:0], read_ext[31:0]};
        end
    end

    assign probe_w[0].valid = launch_reg;
    assign probe_w[0].found = 1'b0;
    assign probe_data_w[0]  = '0;
    assign probe_index_w[0] = '0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] prev_v;
        logic [VALUE_WIDTH-1:0] next_v;

        if (g == 0)
        begin : g_first
            assign prev_v = cell_val;
        end
        else
        begin : g_mid
            assign prev_v = entry_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_v = entry_w[g];
        end
        else
        begin : g_body
            assign next_v = entry_w[g+1];
        end

        olie_cell #(
            .DEPTH       (DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .cell_index      (IDX_W'(g)),
            .ctrl            (ctrl),
            .pos             (cell_pos),
            .count           (count_reg),
            .value           (cell_val),
            .prev_value      (prev_v),
            .next_value      (next_v),
            .entry           (entry_w[g]),
            .probe_in        (probe_w[g]),
            .probe_data_in   (probe_data_w[g]),
            .probe_index_in  (probe_index_w[g]),
            .probe_out       (probe_w[g+1]),
            .probe_data_out  (probe_data_w[g+1]),
            .probe_index_out (probe_index_w[g+1])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule
